// ----- hw/rtl/sqd_pkg.sv -----
package sqd_pkg;

    localparam int unsigned MAX_SERVERS_DEF = 8;
    localparam int unsigned BUF_DEPTH_DEF   = 16;

    localparam int unsigned CNT_W   = 4;
    localparam int unsigned LIM_W   = 5;
    localparam int unsigned TIME_W  = 32;
    localparam int unsigned SIDX_W  = 3;
    localparam int unsigned DROP_W  = 16;
    localparam int unsigned CFG_W   = 5;
    localparam int unsigned CIDX_W  = 1;

    localparam logic [CIDX_W-1:0] REG_SERVER_COUNT = 1'b0;
    localparam logic [CIDX_W-1:0] REG_BUFFER_LIMIT = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RET_RD,
        ST_RET_CHK,
        ST_PICK,
        ST_DECIDE,
        ST_OUT
    } sqd_state_t;

    // controller -> datapath
    typedef struct packed {
        logic load;      // capture input item
        logic srv_clr;   // restart server sweep at 0
        logic srv_inc;   // next server
        logic rd_head;   // issue store read at head of current server
        logic pop;       // retire head of current server
        logic pick_clr;  // restart shortest queue scan
        logic pick_step; // compare one server
        logic commit;    // enqueue or drop, build result
    } sqd_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic srv_last;  // current sweep index is the last server
        logic nonempty;  // current server queue has entries
        logic due;       // read head departure is at or before arrival
        logic pick_last; // scan reached the last enabled server
    } sqd_sts_t;

endpackage

// ----- hw/rtl/shortest_queue_dispatch_finite_buffers_unit.sv -----
// channel  | handshake          | payload
// s_       | s_valid / s_ready  | s_arrival_time, s_service_time
// m_       | m_valid / m_ready  | m_accepted, m_server_index, m_departure_time,
//          |                    | m_wait_time, m_drop_total
// cfg_     | cfg_we             | cfg_idx, cfg_data
// Per item: accept, a head read per server (MAX_SERVERS), a read and check per retired
// entry, a check per server left nonempty, a scan of server_count servers, commit
// and result. The single read port of the departure store sets the retirement pace.
// Reset (aresetn low, synchronous) clears queues and drop count, sets server count
// 1, buffer limit 16. A stalled m_ready holds the result and keeps s_ready low.
module shortest_queue_dispatch_finite_buffers_unit #(
    parameter int unsigned MAX_SERVERS = sqd_pkg::MAX_SERVERS_DEF,
    parameter int unsigned BUF_DEPTH   = sqd_pkg::BUF_DEPTH_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_we,
    input  logic [sqd_pkg::CIDX_W-1:0] cfg_idx,
    input  logic [sqd_pkg::CFG_W-1:0]  cfg_data,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [sqd_pkg::TIME_W-1:0] s_arrival_time,
    input  logic [sqd_pkg::TIME_W-1:0] s_service_time,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic                       m_accepted,
    output logic [sqd_pkg::SIDX_W-1:0] m_server_index,
    output logic [sqd_pkg::TIME_W-1:0] m_departure_time,
    output logic [sqd_pkg::TIME_W-1:0] m_wait_time,
    output logic [sqd_pkg::DROP_W-1:0] m_drop_total
);
    import sqd_pkg::*;

    sqd_cmd_t cmd;
    sqd_sts_t sts;

    // sequencer: retire sweep, shortest-queue scan, commit, output transfer
    sqd_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .sts     (sts)
    );

    // queue state, departure store and result registers
    sqd_dp #(.MAX_SERVERS(MAX_SERVERS), .BUF_DEPTH(BUF_DEPTH)) u_dp (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_we           (cfg_we),
        .cfg_idx          (cfg_idx),
        .cfg_data         (cfg_data),
        .s_arrival_time   (s_arrival_time),
        .s_service_time   (s_service_time),
        .cmd              (cmd),
        .sts              (sts),
        .m_accepted       (m_accepted),
        .m_server_index   (m_server_index),
        .m_departure_time (m_departure_time),
        .m_wait_time      (m_wait_time),
        .m_drop_total     (m_drop_total)
    );
endmodule

// ----- hw/rtl/sqd_ram.sv -----
module sqd_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 128
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ----- hw/rtl/sqd_ctrl.sv -----
module sqd_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    output logic             m_valid,
    input  logic             m_ready,
    output sqd_pkg::sqd_cmd_t cmd,
    input  sqd_pkg::sqd_sts_t sts
);
    import sqd_pkg::*;

    sqd_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:    if (s_valid) state_next = ST_RET_RD;
            ST_RET_RD: begin
                if (sts.nonempty)      state_next = ST_RET_CHK;
                else if (sts.srv_last) state_next = ST_PICK;
            end
            ST_RET_CHK: begin
                if (sts.due)           state_next = ST_RET_RD;
                else if (sts.srv_last) state_next = ST_PICK;
                else                   state_next = ST_RET_RD;
            end
            ST_PICK:    if (sts.pick_last) state_next = ST_DECIDE;
            ST_DECIDE:  state_next = ST_OUT;
            ST_OUT:     if (m_ready) state_next = ST_IDLE;
            default:    state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        m_valid = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready     = 1'b1;
                cmd.load    = s_valid;
                cmd.srv_clr = s_valid;
            end
            ST_RET_RD: begin
                cmd.rd_head  = sts.nonempty;
                cmd.srv_inc  = !sts.nonempty && !sts.srv_last;
                cmd.pick_clr = !sts.nonempty && sts.srv_last;
            end
            ST_RET_CHK: begin
                cmd.pop      = sts.due;
                cmd.srv_inc  = !sts.due && !sts.srv_last;
                cmd.pick_clr = !sts.due && sts.srv_last;
            end
            ST_PICK:   cmd.pick_step = 1'b1;
            ST_DECIDE: cmd.commit    = 1'b1;
            ST_OUT:    m_valid       = 1'b1;
            default: ;
        endcase
    end

    a_one_side: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid)) else $error("ready and valid together");
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid) else $error("result dropped");
    a_pop_due: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.pop |-> state_reg == ST_RET_CHK && sts.nonempty)
        else $error("pop of empty queue");
endmodule

// ----- hw/rtl/sqd_dp.sv -----
module sqd_dp #(
    parameter int unsigned MAX_SERVERS = sqd_pkg::MAX_SERVERS_DEF,
    parameter int unsigned BUF_DEPTH   = sqd_pkg::BUF_DEPTH_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic [sqd_pkg::CIDX_W-1:0]    cfg_idx,
    input  logic [sqd_pkg::CFG_W-1:0]     cfg_data,
    input  logic [sqd_pkg::TIME_W-1:0]    s_arrival_time,
    input  logic [sqd_pkg::TIME_W-1:0]    s_service_time,
    input  sqd_pkg::sqd_cmd_t             cmd,
    output sqd_pkg::sqd_sts_t             sts,
    output logic                          m_accepted,
    output logic [sqd_pkg::SIDX_W-1:0]    m_server_index,
    output logic [sqd_pkg::TIME_W-1:0]    m_departure_time,
    output logic [sqd_pkg::TIME_W-1:0]    m_wait_time,
    output logic [sqd_pkg::DROP_W-1:0]    m_drop_total
);
    import sqd_pkg::*;

    localparam int unsigned SW   = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1;
    localparam int unsigned PW   = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;
    localparam int unsigned FW   = $clog2(BUF_DEPTH + 1);
    localparam int unsigned AW   = $clog2(MAX_SERVERS * BUF_DEPTH);
    localparam int unsigned SCW  = $clog2(MAX_SERVERS + 1);
    localparam int unsigned MW   = (SCW > CNT_W) ? SCW : CNT_W;
    localparam int unsigned LW   = (FW > LIM_W) ? FW : LIM_W;

    logic [CNT_W-1:0] cnt_reg;
    logic [LIM_W-1:0] lim_reg;

    logic [FW-1:0]     fill_reg [MAX_SERVERS];
    logic [PW-1:0]     head_reg [MAX_SERVERS];
    logic [PW-1:0]     tail_reg [MAX_SERVERS];
    logic [TIME_W-1:0] last_reg [MAX_SERVERS];
    logic [DROP_W-1:0] drop_reg;

    logic [TIME_W-1:0] arr_reg, svc_reg;
    logic [SW-1:0]     srv_reg, scan_reg, best_reg;
    logic [FW-1:0]     bfill_reg;

    logic [TIME_W-1:0] rdata;
    logic              we;
    logic [AW-1:0]     waddr, raddr;
    logic [TIME_W-1:0] dep_d;

    // clamped settings
    logic [MW-1:0] cnt_x;
    logic [SW-1:0] last_srv;
    logic [LW-1:0] lim_x;
    always_comb begin
        cnt_x = MW'(cnt_reg);
        if (cnt_x == '0) cnt_x = MW'(1);
        if (cnt_x > MW'(MAX_SERVERS)) cnt_x = MW'(MAX_SERVERS);
        last_srv = SW'(cnt_x - MW'(1));
        lim_x = LW'(lim_reg);
        if (lim_x == '0) lim_x = LW'(1);
        if (lim_x > LW'(BUF_DEPTH)) lim_x = LW'(BUF_DEPTH);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= CNT_W'(1);
            lim_reg <= LIM_W'(16);
        end else if (cfg_we) begin
            unique case (cfg_idx)
                REG_SERVER_COUNT: cnt_reg <= cfg_data[CNT_W-1:0];
                REG_BUFFER_LIMIT: lim_reg <= cfg_data[LIM_W-1:0];
                default: ;
            endcase
        end
    end

    assign sts.srv_last  = (srv_reg == SW'(MAX_SERVERS - 1));
    assign sts.nonempty  = (fill_reg[srv_reg] != '0);
    assign sts.due       = (rdata <= arr_reg);
    assign sts.pick_last = (scan_reg >= last_srv);

    function automatic logic [PW-1:0] ring_next(input logic [PW-1:0] p);
        return (32'(p) + 1 >= BUF_DEPTH) ? '0 : PW'(32'(p) + 1);
    endfunction

    logic [TIME_W:0]   sum;
    logic [TIME_W-1:0] base, w1;
    logic              full;
    always_comb begin
        full  = (LW'(bfill_reg) >= lim_x);
        base  = (bfill_reg != '0) ? last_reg[best_reg] : arr_reg;
        sum   = {1'b0, base} + {1'b0, svc_reg};
        dep_d = sum[TIME_W] ? '1 : sum[TIME_W-1:0];
        w1    = (dep_d > arr_reg) ? dep_d - arr_reg : '0;
    end

    assign we    = cmd.commit && !full;
    assign waddr = AW'(32'(best_reg) * BUF_DEPTH + 32'(tail_reg[best_reg]));
    assign raddr = AW'(32'(srv_reg) * BUF_DEPTH + 32'(head_reg[srv_reg]));

    sqd_ram #(.WIDTH(TIME_W), .DEPTH(MAX_SERVERS * BUF_DEPTH)) u_store (
        .aclk  (aclk),
        .we    (we),
        .waddr (waddr),
        .wdata (dep_d),
        .raddr (raddr),
        .rdata (rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < MAX_SERVERS; i++) begin
                fill_reg[i] <= '0;
                head_reg[i] <= '0;
                tail_reg[i] <= '0;
                last_reg[i] <= '0;
            end
            drop_reg <= '0;
        end else begin
            if (cmd.pop) begin
                head_reg[srv_reg] <= ring_next(head_reg[srv_reg]);
                fill_reg[srv_reg] <= fill_reg[srv_reg] - FW'(1);
            end
            if (cmd.commit) begin
                if (full) begin
                    if (drop_reg != '1) drop_reg <= drop_reg + DROP_W'(1);
                end else begin
                    tail_reg[best_reg] <= ring_next(tail_reg[best_reg]);
                    fill_reg[best_reg] <= bfill_reg + FW'(1);
                    last_reg[best_reg] <= dep_d;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            arr_reg <= s_arrival_time;
            svc_reg <= s_service_time;
        end
        if (cmd.srv_clr)      srv_reg <= '0;
        else if (cmd.srv_inc) srv_reg <= srv_reg + SW'(1);
        if (cmd.pick_clr) begin
            scan_reg  <= '0;
            best_reg  <= '0;
            bfill_reg <= fill_reg[0];
        end else if (cmd.pick_step) begin
            if (fill_reg[scan_reg] < bfill_reg) begin
                best_reg  <= scan_reg;
                bfill_reg <= fill_reg[scan_reg];
            end
            if (!sts.pick_last) scan_reg <= scan_reg + SW'(1);
        end
        if (cmd.commit) begin
            m_accepted       <= !full;
            m_server_index   <= SIDX_W'(best_reg);
            m_departure_time <= full ? '0 : dep_d;
            m_wait_time      <= full ? '0 : ((w1 > svc_reg) ? w1 - svc_reg : '0);
            m_drop_total     <= (full && drop_reg != '1) ? drop_reg + DROP_W'(1)
                                                         : drop_reg;
        end
    end

    a_fill_lim: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit && !full |-> LW'(bfill_reg) < LW'(BUF_DEPTH))
        else $error("enqueue into full ring");
    a_no_mix: assert property (@(posedge aclk) disable iff (!aresetn)
        !(cmd.pop && cmd.commit)) else $error("pop and enqueue overlap");
    a_drop_mono: assert property (@(posedge aclk) disable iff (!aresetn)
        drop_reg >= $past(drop_reg) || $past(!aresetn))
        else $error("drop count decreased");
endmodule
